[hw/rtl/clts_pkg.sv]
// ----------------------------------------------------------------------------
// clts_pkg: shared types and constants of the token scanner
// Holds the transfer structs, token and mode codes, and character classes.
// ----------------------------------------------------------------------------
package clts_pkg;

    localparam int NUMBER_BITS = 63;
    localparam int VALUE_BITS  = 63;
    localparam int Q_DEPTH     = 4;
    localparam int Q_AW        = $clog2(Q_DEPTH);

    localparam logic [NUMBER_BITS-1:0] NUMBER_MAX = {NUMBER_BITS{1'b1}};

    // Token kinds.
    localparam logic [2:0] TK_NUMBER   = 3'd0;
    localparam logic [2:0] TK_OPERATOR = 3'd1;
    localparam logic [2:0] TK_SYMBOL   = 3'd2;
    localparam logic [2:0] TK_STRCHAR  = 3'd3;
    localparam logic [2:0] TK_STREND   = 3'd4;
    localparam logic [2:0] TK_BADCHAR  = 3'd5;
    localparam logic [2:0] TK_UNTERM   = 3'd6;
    localparam logic [2:0] TK_END      = 3'd7;

    // Scanner modes.
    localparam logic [2:0] MODE_IDLE     = 3'd0;
    localparam logic [2:0] MODE_NUMBER   = 3'd1;
    localparam logic [2:0] MODE_OPERATOR = 3'd2;
    localparam logic [2:0] MODE_STRING   = 3'd3;
    localparam logic [2:0] MODE_HALT     = 3'd4;

    // Input item kinds.
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
    } t_in_item;

    typedef struct packed {
        logic [2:0]            token_kind;
        logic [VALUE_BITS-1:0] token_value;
        logic                  overflow;
        logic                  last;
    } t_out_item;

    // Up to two results produced by one scanned item.
    typedef struct packed {
        logic [1:0] count;
        t_out_item  res0;
        t_out_item  res1;
    } t_step_res;

    typedef struct packed {
        logic [Q_AW:0] count;
        logic          room;
    } t_q_status;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_op_char(input logic [7:0] c);
        logic r;
        case (c)
            "+", "-", "*", ">", "<", "^", "%", "!", "=", "~", "|", "&",
            "(", "[", ",", ".", "?": r = 1'b1;
            default:                 r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic never_joins(input logic [7:0] c);
        return (c == "(") || (c == "[") || (c == ",") || (c == ".") ||
               (c == "*") || (c == "?");
    endfunction

    function automatic logic is_symbol(input logic [7:0] c);
        logic r;
        case (c)
            "{", "}", ")", "]", ":", ";", "#", 8'h5C: r = 1'b1;
            default:                                 r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic pair_listed(input logic [7:0] a, input logic [7:0] b);
        logic r;
        case (a)
            "+":     r = (b == "=") || (b == "+");
            "-":     r = (b == "=") || (b == "-") || (b == ">");
            ">":     r = (b == ">") || (b == "=");
            "<":     r = (b == "<") || (b == "=");
            "|":     r = (b == "|");
            "&":     r = (b == "&");
            "!":     r = (b == "=");
            "=":     r = (b == "=");
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic t_out_item make_res(input logic [2:0] kind,
                                           input logic [VALUE_BITS-1:0] value,
                                           input logic ovf);
        t_out_item r;
        r.token_kind  = kind;
        r.token_value = value;
        r.overflow    = ovf;
        r.last        = 1'b0;
        return r;
    endfunction

endpackage

[hw/rtl/clts_core.sv]
// ----------------------------------------------------------------------------
// clts_core: scanner state and single-step token logic
// Holds the scan state and turns one item into up to two results.
// ----------------------------------------------------------------------------
module clts_core import clts_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_item  i_item,
    output t_step_res o_step
);

    logic [2:0]             r_mode;
    logic [NUMBER_BITS-1:0] r_acc;
    logic                   r_sat;
    logic [7:0]             r_op;

    logic [2:0]             n_mode;
    logic [NUMBER_BITS-1:0] n_acc;
    logic                   n_sat;
    logic [7:0]             n_op;

    logic [7:0]             c;
    logic [NUMBER_BITS-1:0] digit;
    logic [NUMBER_BITS+3:0] grown;

    // Outcome of scanning the character from the idle mode.
    logic                   idle_has;
    t_out_item              idle_res;
    logic [2:0]             idle_mode;
    logic [NUMBER_BITS-1:0] idle_acc;
    logic [7:0]             idle_op;

    logic                   a_has;
    t_out_item              a_res;
    logic                   b_has;
    t_out_item              b_res;

    assign c     = i_item.ch;
    assign digit = NUMBER_BITS'(c[3:0]);
    assign grown = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + {4'b0, digit};

    always_comb begin
        idle_has  = 1'b0;
        idle_res  = make_res(TK_NUMBER, '0, 1'b0);
        idle_mode = MODE_IDLE;
        idle_acc  = '0;
        idle_op   = '0;
        if (is_digit(c)) begin
            idle_acc  = digit;
            idle_mode = MODE_NUMBER;
        end else if (is_op_char(c)) begin
            if (never_joins(c)) begin
                idle_has = 1'b1;
                idle_res = make_res(TK_OPERATOR, VALUE_BITS'({c, 8'h00}), 1'b0);
            end else begin
                idle_op   = c;
                idle_mode = MODE_OPERATOR;
            end
        end else if (is_symbol(c)) begin
            idle_has = 1'b1;
            idle_res = make_res(TK_SYMBOL, VALUE_BITS'(c), 1'b0);
        end else if ((c == " ") || (c == 8'h09)) begin
            idle_has = 1'b0;
        end else if (c == 8'h22) begin
            idle_mode = MODE_STRING;
        end else begin
            idle_has  = 1'b1;
            idle_res  = make_res(TK_BADCHAR, VALUE_BITS'(c), 1'b0);
            idle_mode = MODE_HALT;
        end
    end

    always_comb begin
        n_mode = r_mode;
        n_acc  = r_acc;
        n_sat  = r_sat;
        n_op   = r_op;
        a_has  = 1'b0;
        a_res  = make_res(TK_NUMBER, VALUE_BITS'(r_acc), r_sat);
        b_has  = 1'b0;
        b_res  = idle_res;
        if (i_item.kind == KIND_END) begin
            case (r_mode)
                MODE_NUMBER: begin
                    a_has = 1'b1;
                end
                MODE_OPERATOR: begin
                    a_has = 1'b1;
                    a_res = make_res(TK_OPERATOR, VALUE_BITS'({r_op, 8'h00}), 1'b0);
                end
                MODE_STRING: begin
                    a_has = 1'b1;
                    a_res = make_res(TK_UNTERM, '0, 1'b0);
                end
                default: begin
                    a_has = 1'b0;
                end
            endcase
            b_has  = 1'b1;
            b_res  = make_res(TK_END, '0, 1'b0);
            n_mode = MODE_IDLE;
            n_acc  = '0;
            n_sat  = 1'b0;
            n_op   = '0;
        end else begin
            case (r_mode)
                MODE_IDLE: begin
                    b_has  = idle_has;
                    n_mode = idle_mode;
                    n_acc  = idle_acc;
                    n_sat  = 1'b0;
                    n_op   = idle_op;
                end
                MODE_NUMBER: begin
                    if (is_digit(c)) begin
                        if (r_sat || (grown > {4'b0, NUMBER_MAX})) begin
                            n_acc = NUMBER_MAX;
                            n_sat = 1'b1;
                        end else begin
                            n_acc = grown[NUMBER_BITS-1:0];
                        end
                    end else begin
                        a_has  = 1'b1;
                        b_has  = idle_has;
                        n_mode = idle_mode;
                        n_acc  = idle_acc;
                        n_sat  = 1'b0;
                        n_op   = idle_op;
                    end
                end
                MODE_OPERATOR: begin
                    if (pair_listed(r_op, c)) begin
                        b_has  = 1'b1;
                        b_res  = make_res(TK_OPERATOR, VALUE_BITS'({r_op, c}), 1'b0);
                        n_mode = MODE_IDLE;
                        n_op   = '0;
                    end else begin
                        // The waiting operator goes alone; rescan this character.
                        a_has  = 1'b1;
                        a_res  = make_res(TK_OPERATOR, VALUE_BITS'({r_op, 8'h00}), 1'b0);
                        b_has  = idle_has;
                        n_mode = idle_mode;
                        n_acc  = idle_acc;
                        n_sat  = 1'b0;
                        n_op   = idle_op;
                    end
                end
                MODE_STRING: begin
                    b_has = 1'b1;
                    if (c == 8'h22) begin
                        b_res  = make_res(TK_STREND, '0, 1'b0);
                        n_mode = MODE_IDLE;
                    end else begin
                        b_res = make_res(TK_STRCHAR, VALUE_BITS'(c), 1'b0);
                    end
                end
                default: begin
                    n_mode = MODE_HALT;
                end
            endcase
        end
    end

    // Pack the results into the front slots and mark the final one.
    always_comb begin
        o_step.res0 = a_has ? a_res : b_res;
        o_step.res1 = b_res;
        if (a_has && b_has) begin
            o_step.count     = 2'd2;
            o_step.res1.last = 1'b1;
        end else begin
            o_step.count     = (a_has || b_has) ? 2'd1 : 2'd0;
            o_step.res0.last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_acc  <= '0;
            r_sat  <= 1'b0;
            r_op   <= '0;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_sat  <= n_sat;
            r_op   <= n_op;
        end
    end

endmodule

[hw/rtl/clts_resq.sv]
// ----------------------------------------------------------------------------
// clts_resq: result queue
// Takes up to two results a cycle and hands out one per transfer.
// ----------------------------------------------------------------------------
module clts_resq import clts_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_step_res i_step,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item,
    output t_q_status o_status
);

    t_out_item     r_q [Q_DEPTH];
    logic [Q_AW-1:0] r_rd;
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW:0]   r_count;

    logic [Q_AW-1:0] wr_next;
    logic [Q_AW:0]   n_push;
    logic            pop;

    assign wr_next = r_wr + (Q_AW)'(1);
    assign n_push  = i_push ? (Q_AW+1)'(i_step.count) : '0;
    assign pop     = o_valid && !i_stall;

    assign o_valid         = (r_count != '0);
    assign o_item          = r_q[r_rd];
    assign o_status.count  = r_count;
    // Room for the worst case of two results, without counting a pop.
    assign o_status.room   = (r_count <= (Q_AW+1)'(Q_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_push && (i_step.count != 2'd0)) begin
            r_q[r_wr] <= i_step.res0;
        end
        if (i_push && (i_step.count == 2'd2)) begin
            r_q[wr_next] <= i_step.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd    <= '0;
            r_wr    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + n_push[Q_AW-1:0];
            r_rd    <= r_rd + (Q_AW)'(pop);
            r_count <= r_count + n_push - (Q_AW+1)'(pop);
        end
    end

endmodule

[hw/rtl/c_like_token_scanner.sv]
// ----------------------------------------------------------------------------
// c_like_token_scanner: byte-serial scanner for a C-like language
// Turns a stream of characters into number, operator, symbol and string tokens.
// ----------------------------------------------------------------------------
// Usage: the source offers one character, or an end-of-text mark, per transfer
// on i_valid / o_stall / i_item. Results leave one per transfer on
// o_valid / i_stall / o_item; o_item.last flags the final result caused by an
// input item, and an item may cause none, one or two results.
// Path: an accepted item lands in the input register, is scanned once the
// result queue has room for two results; they are written into the queue,
// from which the first result is offered on o_valid / o_item.
// Throughput: one item per cycle while the result queue has room for two
// results; items that give two results are then limited by the output side at
// one result per cycle. The four-entry result queue sets that figure.
// Reset: synchronous and active low; the scanner returns to idle with an empty
// queue. End of text also returns every piece of scan state to its reset value.
// Stall: when the receiver stalls, results gather in the queue; once it lacks
// room for two more, o_stall rises and the held input item waits in place.
// ----------------------------------------------------------------------------
module c_like_token_scanner import clts_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    // Input register: holds one character until the scanner consumes it.
    logic      r_in_valid;
    t_in_item  r_in;

    logic      fire;
    t_step_res step;
    t_q_status q_status;

    // The held character is scanned once the queue can absorb its results.
    assign fire    = r_in_valid && q_status.room;
    assign o_stall = r_in_valid && !q_status.room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in <= i_item;
        end
    end

    clts_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in),
        .o_step  (step)
    );

    clts_resq u_resq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (fire),
        .i_step   (step),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_item   (o_item),
        .o_status (q_status)
    );

    // The queue never holds more results than it has entries.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.count <= (Q_AW+1)'(Q_DEPTH))
        else $error("result queue count beyond its depth");

    // End of text always closes the results of its item.
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_item.token_kind == TK_END)) |-> o_item.last)
        else $error("end token without last flag");

    // A held character is not replaced while the scanner waits for room.
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> (r_in_valid && $stable(r_in)))
        else $error("held input character lost while stalled");

    // The overflow flag only travels with number tokens.
    a_ovf_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.overflow) |-> (o_item.token_kind == TK_NUMBER))
        else $error("overflow flag on a non-number token");

    // After a reset cycle no result is offered.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result offered right after reset");

endmodule

[dv/c_like_token_scanner_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_like_token_scanner_tb: self-checking bench for the byte-serial token scanner
// A scoreboard predicts the tokens of every accepted character or end-of-text
// transfer. Each token that leaves the scanner is checked field by field
// against the oldest prediction. Directed tests come first, then a back-pressure
// test and a long random character stream made mostly of well-formed tokens.
// ----------------------------------------------------------------------------
module c_like_token_scanner_tb;
    import clts_pkg::*;

    // Run limits. The drain wait covers the scan and result queue path with margin.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 60;

    // Character classes of the scanner, kept as plain byte lists. Operators
    // that never wait for a partner are listed apart, and the joined pairs
    // are stored back to back, two bytes per operator.
    string op_chars  = "+-*><^%!=~|&([,.?";
    string lone_ops  = "([,.*?";
    string sym_chars = "{})]:;#\\";
    string joined    = "+=-=>><<>=<=||&&++--!===->";

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    t_in_item  i_item  = '0;
    logic      i_stall = 1'b0;
    logic      o_stall;
    logic      o_valid;
    t_out_item o_item;

    // Pacing controls shared between the test sequence and the driver processes.
    bit tx_gaps = 1'b0;
    bit rx_gaps = 1'b0;
    bit hold_rx = 1'b0;

    int items_sent   = 0;
    int tokens_seen  = 0;
    int error_count  = 0;
    int cycle_count  = 0;

    // Scoreboard copy of the scanner state.
    logic [2:0]             scan_state = MODE_IDLE;
    logic [NUMBER_BITS-1:0] num_value  = '0;
    logic                   num_sat    = 1'b0;
    logic [7:0]             held_op    = 8'h00;

    // Tokens of the transfer being predicted, then the ordered list of tokens
    // still owed by the scanner.
    t_out_item step_tokens[$];
    t_out_item expected_tokens[$];

    c_like_token_scanner dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // The whole run is bounded by a plain cycle count, so a hung handshake or a
    // token that never arrives ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Token prediction
    // ------------------------------------------------------------------------

    function automatic bit in_set(input logic [7:0] c, input string s);
        for (int i = 0; i < s.len(); i++) begin
            if (s[i] == c) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit forms_pair(input logic [7:0] a, input logic [7:0] b);
        for (int i = 0; i < joined.len(); i += 2) begin
            if (joined[i] == a && joined[i+1] == b) return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic add_token(input logic [2:0] kind, input logic [VALUE_BITS-1:0] value,
                             input logic ovf);
        t_out_item t;
        t.token_kind  = kind;
        t.token_value = value;
        t.overflow    = ovf;
        t.last        = 1'b0;
        step_tokens.push_back(t);
    endtask

    // Flushing a number also clears the accumulator, as the scanner does.
    task automatic flush_number();
        add_token(TK_NUMBER, num_value, num_sat);
        num_value = '0;
        num_sat   = 1'b0;
    endtask

    // Scan one character from the idle state. This is also where a character
    // lands after it has ended a number or failed to join a waiting operator.
    task automatic scan_fresh(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            num_value  = c - "0";
            num_sat    = 1'b0;
            scan_state = MODE_NUMBER;
        end else if (in_set(c, op_chars)) begin
            if (in_set(c, lone_ops)) begin
                add_token(TK_OPERATOR, {c, 8'h00}, 1'b0);
            end else begin
                held_op    = c;
                scan_state = MODE_OPERATOR;
            end
        end else if (in_set(c, sym_chars)) begin
            add_token(TK_SYMBOL, c, 1'b0);
        end else if (c == " " || c == 8'h09) begin
            // Whitespace produces nothing.
        end else if (c == "\"") begin
            scan_state = MODE_STRING;
        end else begin
            // Anything unrecognized halts the scanner until end of text.
            add_token(TK_BADCHAR, c, 1'b0);
            scan_state = MODE_HALT;
        end
    endtask

    task automatic predict_tokens(input t_in_item it);
        logic [NUMBER_BITS-1:0] digit;
        logic [7:0]             first;
        t_out_item              t;
        step_tokens.delete();
        if (it.kind == KIND_END) begin
            // End of text flushes whatever is open and always closes with an
            // end token; the scanner then starts over from its reset state.
            case (scan_state)
                MODE_NUMBER:   flush_number();
                MODE_OPERATOR: add_token(TK_OPERATOR, {held_op, 8'h00}, 1'b0);
                MODE_STRING:   add_token(TK_UNTERM, '0, 1'b0);
                default: ;
            endcase
            add_token(TK_END, '0, 1'b0);
            scan_state = MODE_IDLE;
            num_value  = '0;
            num_sat    = 1'b0;
            held_op    = 8'h00;
        end else begin
            case (scan_state)
                MODE_IDLE: begin
                    scan_fresh(it.ch);
                end
                MODE_NUMBER: begin
                    if (it.ch >= "0" && it.ch <= "9") begin
                        // Saturate at the all-ones value and keep it there.
                        digit = it.ch - "0";
                        if (num_sat || num_value > (NUMBER_MAX - digit) / 10) begin
                            num_value = NUMBER_MAX;
                            num_sat   = 1'b1;
                        end else begin
                            num_value = num_value * 10 + digit;
                        end
                    end else begin
                        flush_number();
                        scan_state = MODE_IDLE;
                        scan_fresh(it.ch);
                    end
                end
                MODE_OPERATOR: begin
                    first      = held_op;
                    held_op    = 8'h00;
                    scan_state = MODE_IDLE;
                    if (forms_pair(first, it.ch)) begin
                        add_token(TK_OPERATOR, {first, it.ch}, 1'b0);
                    end else begin
                        // The waiting operator leaves alone and the character
                        // is scanned again from scratch.
                        add_token(TK_OPERATOR, {first, 8'h00}, 1'b0);
                        scan_fresh(it.ch);
                    end
                end
                MODE_STRING: begin
                    if (it.ch == "\"") begin
                        add_token(TK_STREND, '0, 1'b0);
                        scan_state = MODE_IDLE;
                    end else begin
                        add_token(TK_STRCHAR, it.ch, 1'b0);
                    end
                end
                default: ;
            endcase
        end
        if (step_tokens.size() > 0) begin
            t = step_tokens.pop_back();
            t.last = 1'b1;
            step_tokens.push_back(t);
        end
        foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
    endtask

    // Every accepted input transfer feeds the scoreboard. Values are sampled
    // right after the edge, before any nonblocking update of that edge lands.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) predict_tokens(i_item);
    end

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] MISMATCH token %0d: %s", $realtime, tokens_seen, msg);
    endtask

    always @(posedge i_clk) begin : check_tokens
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_tokens.size() == 0) begin
                report_mismatch($sformatf("unexpected token kind %0d value %0h",
                                          o_item.token_kind, o_item.token_value));
            end else begin
                want = expected_tokens.pop_front();
                if (o_item.token_kind !== want.token_kind)
                    report_mismatch($sformatf("token_kind %0d, expected %0d",
                                              o_item.token_kind, want.token_kind));
                if (o_item.token_value !== want.token_value)
                    report_mismatch($sformatf("token_value %0h, expected %0h",
                                              o_item.token_value, want.token_value));
                if (o_item.overflow !== want.overflow)
                    report_mismatch($sformatf("overflow %0b, expected %0b",
                                              o_item.overflow, want.overflow));
                if (o_item.last !== want.last)
                    report_mismatch($sformatf("last %0b, expected %0b",
                                              o_item.last, want.last));
            end
            tokens_seen++;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver pacing
    // ------------------------------------------------------------------------

    // Short random stall bursts while enabled. A hold request from the test
    // sequence stalls the receiver for a long fixed stretch, long enough for
    // the result queue to fill and push back on the input side.
    initial begin : rx_pacing
        forever begin
            @(posedge i_clk);
            if (hold_rx) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_stall <= 1'b0;
                hold_rx = 1'b0;
            end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Offer one item and return at the edge where its transfer happens. Valid
    // is left high so that back-to-back items keep the channel busy; a random
    // gap, when taken, drops it at the start of the next call.
    task automatic send_item(input logic kind, input logic [7:0] ch);
        t_in_item it;
        it.kind = kind;
        it.ch   = ch;
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_item(KIND_CHAR, s[i]);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Zero alone, numbers with leading zeros, and a number still open when
    // the text ends. The end mark carries an all-ones byte that must be ignored.
    task automatic test_numbers();
        send_text("0 007 42");
        send_item(KIND_END, 8'hFF);
    endtask

    // A joined pair, operators that never wait, pairs that do not join (the
    // second character then goes through the normal scan), a symbol, tab and
    // space skipping, the arrow, and an operator left waiting at end of text.
    task automatic test_operators();
        send_text("==!*%}\t& ->[+-");
        send_item(KIND_END, 8'h00);
    endtask

    // String bodies pass every byte through, including NUL and 0xFF, and a
    // string still open at end of text is reported as unterminated.
    task automatic test_strings();
        send_text("\"a");
        send_item(KIND_CHAR, 8'h00);
        send_item(KIND_CHAR, 8'hFF);
        send_text("\"\"b");
        send_item(KIND_END, 8'h00);
    endtask

    // A digit followed by NUL gives a number and a bad char from one transfer.
    // The halted scanner ignores everything up to end of text. A slash is bad
    // after an operator that cannot take it, and bad on its own.
    task automatic test_bad_chars();
        send_text("5");
        send_item(KIND_CHAR, 8'h00);
        send_text("x;");
        send_item(KIND_END, 8'h00);
        send_text("-/");
        send_item(KIND_CHAR, 8'h0A);
        send_item(KIND_END, 8'h00);
        send_text("/");
        send_item(KIND_END, 8'hA5);
        // End of text with nothing open gives the end token alone.
        send_item(KIND_END, 8'h5A);
    endtask

    // Stall the receiver for a long stretch while the sender keeps offering
    // items; several of them produce two tokens, so the queue fills quickly.
    task automatic test_backpressure();
        hold_rx = 1'b1;
        send_text("1;2;3+=4;(;5 6;7;!8");
        send_item(KIND_END, 8'h00);
    endtask

    // Random stream built from whole tokens with random content: numbers
    // (some long enough to saturate), operators alone and in pairs, symbols,
    // whitespace, strings, end marks, plus a little noise that usually halts
    // the scanner and is then closed by an end mark.
    task automatic test_random_stream(input int count);
        int         start;
        int         len;
        int         k;
        logic [7:0] b;
        start = items_sent;
        while (items_sent - start < count) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4: begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(19, 21)
                                                      : $urandom_range(1, 3);
                    repeat (len) begin
                        b = "0" + $urandom_range(0, 9);
                        send_item(KIND_CHAR, b);
                    end
                end
                5, 6, 7, 8: begin
                    b = op_chars[$urandom_range(0, op_chars.len() - 1)];
                    send_item(KIND_CHAR, b);
                end
                9, 10: begin
                    k = 2 * $urandom_range(0, joined.len() / 2 - 1);
                    send_item(KIND_CHAR, joined[k]);
                    send_item(KIND_CHAR, joined[k+1]);
                end
                11, 12: begin
                    b = sym_chars[$urandom_range(0, sym_chars.len() - 1)];
                    send_item(KIND_CHAR, b);
                end
                13, 14: begin
                    b = $urandom_range(0, 1) ? " " : 8'h09;
                    send_item(KIND_CHAR, b);
                end
                15, 16, 19: begin
                    send_item(KIND_CHAR, "\"");
                    repeat ($urandom_range(0, 5)) begin
                        b = $urandom_range(0, 255);
                        send_item(KIND_CHAR, b);
                    end
                    if ($urandom_range(0, 5) == 0) begin
                        b = $urandom_range(0, 255);
                        send_item(KIND_END, b);
                    end else begin
                        send_item(KIND_CHAR, "\"");
                    end
                end
                17: begin
                    b = $urandom_range(0, 255);
                    send_item(KIND_END, b);
                end
                default: begin
                    repeat ($urandom_range(1, 3)) begin
                        b = $urandom_range(0, 255);
                        send_item(KIND_CHAR, b);
                    end
                    b = $urandom_range(0, 255);
                    send_item(KIND_END, b);
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        test_numbers();
        test_operators();
        test_strings();
        test_bad_chars();
        test_backpressure();
        test_random_stream(250);

        // The closing stretch runs at full rate on both sides.
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        test_random_stream(130);
        send_item(KIND_END, 8'h00);
        i_valid <= 1'b0;

        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
